// ===== rtl/gregorian_date_advance_top_assert.svh =====
// Assertion helpers for the date advance block.
// Both macros sample on the rising edge of clock and are off while reset is high.
`ifndef GREGORIAN_DATE_ADVANCE_TOP_ASSERT_SVH
`define GREGORIAN_DATE_ADVANCE_TOP_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define GDA_CHECK(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("date advance check failed");

// The condition must hold in the cycle after the trigger.
`define GDA_CHECK_NEXT(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("date advance check failed");

`endif

// ===== rtl/gda_pkg.sv =====
package gda_pkg;

   localparam int INTERVAL_BITS = 8;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 12;
   localparam int IVL_W   = 8;
   localparam int WDAY_W  = 3;

   // Interval bits actually used and the day counter that holds day plus interval.
   localparam int N_USE   = (INTERVAL_BITS < IVL_W) ? INTERVAL_BITS : IVL_W;
   localparam int DCNT_W  = $clog2(31 + (2 ** N_USE));
   // One month boundary per step stage; every month has at least 28 days.
   localparam int STEPS   = ((2 ** N_USE) + 30) / 28 + 1;

   localparam logic [YEAR_W-1:0]  YEAR_TOP  = 12'd4095;
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;

   // Reciprocal constants: x / 100 = (x * 5243) >> 19 for x below 43699,
   // x / 7 = (x * 9363) >> 16 for x below 8192.
   localparam int            PROD_W    = 25;
   localparam logic [PROD_W-1:0] RECIP100 = 25'd5243;
   localparam int            SUM_W     = 13;
   localparam int            PROD7_W   = 27;
   localparam logic [PROD7_W-1:0] RECIP7  = 27'd9363;
   localparam logic [SUM_W-1:0]   YEAR_SHIFT = 13'd400;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic [IVL_W-1:0]   interval_days;
      logic [PROD_W-1:0]  year_prod;
   } in_type;

   typedef struct packed {
      logic [DCNT_W-1:0]  day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic [6:0]         rem100;
      logic [1:0]         cent_lo;
      logic               invalid;
      logic               ovf;
      logic [WDAY_W-1:0]  weekday;
   } item_type;

   typedef struct packed {
      logic [DAY_W-1:0]   day_out;
      logic [MONTH_W-1:0] month_out;
      logic [YEAR_W-1:0]  year_out;
      logic [WDAY_W-1:0]  weekday;
      logic               date_invalid;
      logic               year_overflow;
   } out_type;

   // A year is leap when it divides by 4 and not by 100, or when it divides by 400.
   function automatic logic is_leap(logic [1:0] year_lo, logic [6:0] rem100,
                                    logic [1:0] cent_lo);
      return ((year_lo == 2'd0) && (rem100 != 7'd0)) ||
             ((rem100 == 7'd0) && (cent_lo == 2'd0));
   endfunction

   function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] month, logic leap);
      logic [DAY_W-1:0] len;
      len = 5'd31;
      if (month == MONTH_FEB) begin
         len = leap ? 5'd29 : 5'd28;
      end else if (month == MONTH_APR || month == MONTH_JUN ||
                   month == MONTH_SEP || month == MONTH_NOV) begin
         len = 5'd30;
      end
      return len;
   endfunction

   function automatic logic [2:0] month_off(logic [MONTH_W-1:0] month);
      logic [2:0] off;
      unique case (month)
         4'd1:    off = 3'd0;
         4'd2:    off = 3'd3;
         4'd3:    off = 3'd2;
         4'd4:    off = 3'd5;
         4'd5:    off = 3'd0;
         4'd6:    off = 3'd3;
         4'd7:    off = 3'd5;
         4'd8:    off = 3'd1;
         4'd9:    off = 3'd4;
         4'd10:   off = 3'd6;
         4'd11:   off = 3'd2;
         4'd12:   off = 3'd4;
         default: off = 3'd0;
      endcase
      return off;
   endfunction

   // Crosses at most one month boundary.
   function automatic item_type step_month(item_type cur);
      item_type         nxt;
      logic [DAY_W-1:0] len;
      nxt = cur;
      len = month_len(cur.month, is_leap(cur.year[1:0], cur.rem100, cur.cent_lo));
      if (!cur.invalid && !cur.ovf && (cur.day > DCNT_W'(len))) begin
         nxt.day = cur.day - DCNT_W'(len);
         if (cur.month == MONTH_DEC) begin
            nxt.month = MONTH_JAN;
            if (cur.year == YEAR_TOP) begin
               nxt.ovf = 1'b1;
            end else begin
               nxt.year = cur.year + 12'd1;
               if (cur.rem100 == 7'd99) begin
                  nxt.rem100  = 7'd0;
                  nxt.cent_lo = cur.cent_lo + 2'd1;
               end else begin
                  nxt.rem100 = cur.rem100 + 7'd1;
               end
            end
         end else begin
            nxt.month = cur.month + 4'd1;
         end
      end
      return nxt;
   endfunction

endpackage

// ===== rtl/gda_if.sv =====
interface gda_req_if import gda_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DAY_W-1:0]     day_in;
   logic [MONTH_W-1:0]   month_in;
   logic [YEAR_W-1:0]    year_in;
   logic [IVL_W-1:0]     interval_days;

   modport source (output valid, day_in, month_in, year_in, interval_days, input ready);
   modport sink (input valid, day_in, month_in, year_in, interval_days, output ready);
endinterface

interface gda_rsp_if import gda_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DAY_W-1:0]     day_out;
   logic [MONTH_W-1:0]   month_out;
   logic [YEAR_W-1:0]    year_out;
   logic [WDAY_W-1:0]    weekday;
   logic                 date_invalid;
   logic                 year_overflow;

   modport source (output valid, day_out, month_out, year_out, weekday, date_invalid,
                   year_overflow, input ready);
   modport sink (input valid, day_out, month_out, year_out, weekday, date_invalid,
                 year_overflow, output ready);
endinterface

// ===== rtl/gregorian_date_advance_top.sv =====
// Gregorian date advance.
// A beat on req_chan carries a start date and a day interval; one beat on
// rsp_chan returns the advanced date, the weekday of the start date and the
// invalid and overflow flags, in the order the requests came in.
// The block is a pipeline of 17 register stages: five stages check the date
// and compute the weekday with reciprocal multiplies, eleven stages each carry
// the date across at most one month end, and one output register follows.
// A new request beat is taken in every cycle while responses drain.
// The month-step stages set the depth; their count follows from the widest
// interval, since each month has at least 28 days.
// When the receiver holds rsp_chan.ready low with a response waiting, the
// whole pipeline holds and req_chan.ready drops; nothing is lost or repeated.
// Synchronous reset clears all valid bits, so the pipeline comes up empty
// and ready to take a request beat in the first cycle after reset.
`include "gregorian_date_advance_top_assert.svh"

module gregorian_date_advance_top import gda_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   gda_req_if.sink   req_chan,
   gda_rsp_if.source rsp_chan
);

   localparam int NSTG  = STEPS + 6;
   localparam int E_IDX = 4;

   logic                adv;
   logic [NSTG-1:0]     vld_ff;
   logic [NSTG-1:0]     vld_in;

   in_type              a_ff, a_in;
   item_type            b_item_ff, b_item_in;
   logic [DAY_W-1:0]    b_day0_ff, b_day0_in;
   logic [SUM_W-1:0]    b_yy_ff, b_yy_in;
   logic [PROD_W-1:0]   b_prod_ff, b_prod_in;
   item_type            c_item_ff;
   logic [SUM_W-1:0]    c_sum_ff, c_sum_in;
   item_type            d_item_ff;
   logic [SUM_W-1:0]    d_sum_ff;
   logic [PROD7_W-1:0]  d_prod_ff, d_prod_in;
   item_type            stp_ff [0:STEPS];
   item_type            stp_in [0:STEPS];
   out_type             rsp_ff, rsp_in;

   logic [5:0]          cent;
   logic [YEAR_W-1:0]   cent_hun;
   logic [6:0]          rem100;
   logic                leap;
   logic [DAY_W-1:0]    len;
   logic                date_ok;
   logic [5:0]          yy_cent;
   logic [10:0]         q7;
   logic [SUM_W-1:0]    wd_rem;

   assign adv            = !vld_ff[NSTG-1] || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign vld_in         = {vld_ff[NSTG-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      a_in.day           = req_chan.day_in;
      a_in.month         = req_chan.month_in;
      a_in.year          = req_chan.year_in;
      a_in.interval_days = req_chan.interval_days;
      a_in.year_prod     = PROD_W'(req_chan.year_in) * RECIP100;
   end

   always_comb begin
      cent     = a_ff.year_prod[24:19];
      cent_hun = YEAR_W'(cent) * 12'd100;
      rem100   = 7'(a_ff.year - cent_hun);
      leap     = is_leap(a_ff.year[1:0], rem100, cent[1:0]);
      len      = month_len(a_ff.month, leap);
      date_ok  = (a_ff.month >= MONTH_JAN) && (a_ff.month <= MONTH_DEC) &&
                 (a_ff.day != '0) && (a_ff.day <= len);

      b_item_in.day     = date_ok ? DCNT_W'(a_ff.day) + DCNT_W'(a_ff.interval_days[N_USE-1:0])
                                  : DCNT_W'(a_ff.day);
      b_item_in.month   = a_ff.month;
      b_item_in.year    = a_ff.year;
      b_item_in.rem100  = rem100;
      b_item_in.cent_lo = cent[1:0];
      b_item_in.invalid = !date_ok;
      b_item_in.ovf     = 1'b0;
      b_item_in.weekday = '0;

      // January and February count with the previous year.
      b_day0_in = a_ff.day;
      b_yy_in   = SUM_W'(a_ff.year) + YEAR_SHIFT - SUM_W'(a_ff.month < MONTH_MAR);
      b_prod_in = PROD_W'(b_yy_in) * RECIP100;
   end

   always_comb begin
      yy_cent  = b_prod_ff[24:19];
      c_sum_in = b_yy_ff + SUM_W'(b_yy_ff[SUM_W-1:2]) - SUM_W'(yy_cent)
               + SUM_W'(yy_cent[5:2]) + SUM_W'(month_off(b_item_ff.month))
               + SUM_W'(b_day0_ff);
   end

   assign d_prod_in = PROD7_W'(c_sum_ff) * RECIP7;

   always_comb begin
      q7     = d_prod_ff[26:16];
      wd_rem = d_sum_ff - SUM_W'(q7) * 13'd7;
      stp_in[0]         = d_item_ff;
      stp_in[0].weekday = d_item_ff.invalid ? '0 : wd_rem[WDAY_W-1:0];
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      assign stp_in[i+1] = step_month(stp_ff[i]);
   end

   always_comb begin
      rsp_in.weekday       = stp_ff[STEPS].weekday;
      rsp_in.date_invalid  = stp_ff[STEPS].invalid;
      rsp_in.year_overflow = stp_ff[STEPS].ovf;
      if (stp_ff[STEPS].ovf) begin
         rsp_in.day_out   = DAY_LAST;
         rsp_in.month_out = MONTH_DEC;
         rsp_in.year_out  = YEAR_TOP;
      end else begin
         rsp_in.day_out   = stp_ff[STEPS].day[DAY_W-1:0];
         rsp_in.month_out = stp_ff[STEPS].month;
         rsp_in.year_out  = stp_ff[STEPS].year;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff      <= a_in;
         b_item_ff <= b_item_in;
         b_day0_ff <= b_day0_in;
         b_yy_ff   <= b_yy_in;
         b_prod_ff <= b_prod_in;
         c_item_ff <= b_item_ff;
         c_sum_ff  <= c_sum_in;
         d_item_ff <= c_item_ff;
         d_sum_ff  <= c_sum_ff;
         d_prod_ff <= d_prod_in;
         for (int i = 0; i <= STEPS; i++) begin
            stp_ff[i] <= stp_in[i];
         end
         rsp_ff    <= rsp_in;
      end
   end

   assign rsp_chan.valid         = vld_ff[NSTG-1];
   assign rsp_chan.day_out       = rsp_ff.day_out;
   assign rsp_chan.month_out     = rsp_ff.month_out;
   assign rsp_chan.year_out      = rsp_ff.year_out;
   assign rsp_chan.weekday       = rsp_ff.weekday;
   assign rsp_chan.date_invalid  = rsp_ff.date_invalid;
   assign rsp_chan.year_overflow = rsp_ff.year_overflow;

   // An invalid date never overflows and reports Sunday.
   `GDA_CHECK(a_invalid_clean, vld_ff[NSTG-1] && rsp_ff.date_invalid,
      !rsp_ff.year_overflow && (rsp_ff.weekday == '0))
   // An overflow saturates to the last day of the top year.
   `GDA_CHECK(a_ovf_saturates, vld_ff[NSTG-1] && rsp_ff.year_overflow,
      (rsp_ff.day_out == DAY_LAST) && (rsp_ff.month_out == MONTH_DEC) &&
      (rsp_ff.year_out == YEAR_TOP))
   // After the last step stage, a valid date lies within its month.
   `GDA_CHECK(a_steps_done, vld_ff[NSTG-2] && !stp_ff[STEPS].invalid && !stp_ff[STEPS].ovf,
      (stp_ff[STEPS].day != '0) &&
      (stp_ff[STEPS].day <= DCNT_W'(month_len(stp_ff[STEPS].month,
         is_leap(stp_ff[STEPS].year[1:0], stp_ff[STEPS].rem100, stp_ff[STEPS].cent_lo)))))
   // The weekday of a valid date is in range.
   `GDA_CHECK(a_weekday_range, vld_ff[E_IDX] && !stp_ff[0].invalid,
      stp_ff[0].weekday <= 3'd6)
   // A stalled response holds, and the pipeline behind it holds too.
   `GDA_CHECK_NEXT(a_stall_holds, vld_ff[NSTG-1] && !rsp_chan.ready,
      vld_ff[NSTG-1] && $stable(rsp_ff) && $stable(vld_ff))

endmodule
